FILE: rtl/ptt_pkg.sv
// ptt_pkg: types, constants and state codes for the process tick timer table
// used by process_tick_timer_table; no dependencies
package ptt_pkg;

  localparam int NUM_PROC = 16;
  localparam int IDX_W = $clog2(NUM_PROC);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PROC - 1);

  localparam logic [21:0] WINDOW_US = 22'd2000000;
  localparam logic [19:0] PPM_FULL = 20'd1000000;
  localparam logic [20:0] BUSY_MAX = 21'h1FFFFF;
  localparam logic [19:0] IV_RESET = 20'd10000;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_SLEEP = 2'd1;
  localparam logic [1:0] ACT_SET = 2'd2;

  localparam logic [1:0] KIND_WAKE = 2'd0;
  localparam logic [1:0] KIND_USE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [0:0] REG_IV = 1'b0;

  localparam logic [4:0] TDIV_STEPS = 5'd22;
  localparam logic [4:0] UDIV_STEPS = 5'd20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TDIV,
    ST_SLOT,
    ST_MUL,
    ST_DLD,
    ST_UDIV,
    ST_USE,
    ST_SLEEP,
    ST_WAKE,
    ST_EXEC,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/process_tick_timer_table.sv
// process_tick_timer_table: process sleep, blocked, active and busy tables with uptime
// clock; one shared restoring divider under a sequencer; depends on ptt_pkg
// a non-tick request yields only its done item; a report tick first runs 22 divider steps
// for the tick count, then each tick walks the slots (active: usage item on a report tick,
// sleep countdown, wake item at expiry), may bump the executing busy count, ends in done
// one request at a time, in idle; out_tready stalls; sync rst_n clears control, not datapath
module process_tick_timer_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // process[3:0] sleep_ticks[27:4] active[28] rtc_second[34:29] executing[38:35]
  // executing_valid[39]
  input  logic [39:0] in_tdata,
  // action[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot[3:0] usage_ppm[23:4] up_days[39:24] up_hours[44:40] up_minutes[50:45]
  // up_seconds[56:51]
  output logic [63:0] out_tdata,
  // kind[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ptt_pkg::*;

  state_t state_r, state_nxt;

  logic [19:0] iv_r;
  logic [NUM_PROC-1:0] act_r, act_nxt, blk_r, blk_nxt;
  logic [23:0] sleep_r [NUM_PROC];
  logic [23:0] sleep_nxt [NUM_PROC];
  logic [20:0] busy_r [NUM_PROC];
  logic [20:0] busy_nxt [NUM_PROC];
  logic [21:0] win_r, win_nxt;
  logic [5:0]  lrtc_r, lrtc_nxt;
  logic        seen_r, seen_nxt;
  logic [5:0]  sec_r, sec_nxt, min_r, min_nxt;
  logic [4:0]  hr_r, hr_nxt;
  logic [15:0] day_r, day_nxt;
  logic        rep_r, rep_nxt;
  logic [3:0]  exe_r, exe_nxt;
  logic        exev_r, exev_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [21:0] ticks_r, ticks_nxt;
  logic [40:0] prod_r, prod_nxt;
  logic [22:0] rem_r, rem_nxt;
  logic [21:0] dvd_r, dvd_nxt;
  logic [21:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [19:0] ppm_r, ppm_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [3:0]  oslot_r, oslot_nxt;
  logic [19:0] oppm_r, oppm_nxt;
  logic        olast_r, olast_nxt;
  logic [32:0] oup_r, oup_nxt;

  logic        in_acc, ofree, cfg_wr;
  logic [1:0]  i_action;
  logic [3:0]  i_proc, i_exe;
  logic [23:0] i_sticks;
  logic        i_active, i_exev;
  logic [5:0]  i_rtc;
  logic [19:0] iv_eff;
  logic [21:0] win_add;
  logic [22:0] rem_sh;
  logic        rem_ge;
  logic [22:0] rem_sub;
  logic        proc_ok, exe_ok;

  assign i_proc   = in_tdata[3:0];
  assign i_sticks = in_tdata[27:4];
  assign i_active = in_tdata[28];
  assign i_rtc    = in_tdata[34:29];
  assign i_exe    = in_tdata[38:35];
  assign i_exev   = in_tdata[39];
  assign i_action = in_tuser;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign ofree = !ov_r || out_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_IV) ? {12'd0, iv_r} : 32'd0;

  assign iv_eff = (iv_r == 20'd0) ? 20'd1 : iv_r;
  assign win_add = win_r + {2'd0, iv_eff};
  assign proc_ok = {1'b0, i_proc} < 5'(NUM_PROC);
  assign exe_ok = exev_r && ({1'b0, exe_r} < 5'(NUM_PROC));

  // shared restoring divider step
  assign rem_sh = {rem_r[21:0], dvd_r[21]};
  assign rem_ge = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  assign out_tvalid = ov_r;
  assign out_tuser = okind_r;
  assign out_tlast = olast_r;
  assign out_tdata = {7'd0, oup_r, oppm_r, oslot_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (i_action == ACT_TICK) begin
            state_nxt = (win_add >= WINDOW_US) ? ST_TDIV : ST_SLOT;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_TDIV: if (cnt_r == 5'd1) state_nxt = ST_SLOT;
      ST_SLOT: begin
        if (!act_r[idx_r]) begin
          state_nxt = (idx_r == LAST_IDX) ? ST_EXEC : ST_SLOT;
        end else if (rep_r) begin
          state_nxt = (busy_r[idx_r] >= ticks_r[20:0] || ticks_r[21]) ?
                      ((ticks_r[21]) ? ST_MUL : ST_USE) : ST_MUL;
        end else begin
          state_nxt = ST_SLEEP;
        end
      end
      ST_MUL: state_nxt = ST_DLD;
      ST_DLD: state_nxt = ST_UDIV;
      ST_UDIV: if (cnt_r == 5'd1) state_nxt = ST_USE;
      ST_USE: if (ofree) state_nxt = ST_SLEEP;
      ST_SLEEP: begin
        if (sleep_r[idx_r] == 24'd1) begin
          state_nxt = ST_WAKE;
        end else begin
          state_nxt = (idx_r == LAST_IDX) ? ST_EXEC : ST_SLOT;
        end
      end
      ST_WAKE: if (ofree) state_nxt = (idx_r == LAST_IDX) ? ST_EXEC : ST_SLOT;
      ST_EXEC: state_nxt = ST_DONE;
      ST_DONE: if (ofree) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    act_nxt = act_r;
    blk_nxt = blk_r;
    sleep_nxt = sleep_r;
    busy_nxt = busy_r;
    win_nxt = win_r;
    lrtc_nxt = lrtc_r;
    seen_nxt = seen_r;
    sec_nxt = sec_r;
    min_nxt = min_r;
    hr_nxt = hr_r;
    day_nxt = day_r;
    rep_nxt = rep_r;
    exe_nxt = exe_r;
    exev_nxt = exev_r;
    idx_nxt = idx_r;
    ticks_nxt = ticks_r;
    prod_nxt = prod_r;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    ppm_nxt = ppm_r;
    ov_nxt = ov_r && !out_tready;
    okind_nxt = okind_r;
    oslot_nxt = oslot_r;
    oppm_nxt = oppm_r;
    olast_nxt = olast_r;
    oup_nxt = oup_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt = '0;
          exe_nxt = i_exe;
          exev_nxt = i_exev;
          ticks_nxt = 22'd1;
          if (i_action == ACT_TICK) begin
            if (!seen_r) begin
              seen_nxt = 1'b1;
              lrtc_nxt = i_rtc;
            end else if (lrtc_r != i_rtc) begin
              lrtc_nxt = i_rtc;
              if (sec_r >= 6'd59) begin
                sec_nxt = '0;
                if (min_r >= 6'd59) begin
                  min_nxt = '0;
                  if (hr_r >= 5'd23) begin
                    hr_nxt = '0;
                    day_nxt = day_r + 16'd1;
                  end else begin
                    hr_nxt = hr_r + 5'd1;
                  end
                end else begin
                  min_nxt = min_r + 6'd1;
                end
              end else begin
                sec_nxt = sec_r + 6'd1;
              end
            end
            win_nxt = win_add;
            rep_nxt = win_add >= WINDOW_US;
            rem_nxt = '0;
            dvd_nxt = win_add;
            dvs_nxt = {2'd0, iv_eff};
            cnt_nxt = TDIV_STEPS;
          end else if (i_action == ACT_SLEEP) begin
            if (i_sticks != 24'd0 && proc_ok) begin
              sleep_nxt[i_proc[IDX_W-1:0]] = i_sticks;
              blk_nxt[i_proc[IDX_W-1:0]] = 1'b1;
            end
          end else if (i_action == ACT_SET) begin
            if (proc_ok) begin
              act_nxt[i_proc[IDX_W-1:0]] = i_active;
              if (i_active) begin
                sleep_nxt[i_proc[IDX_W-1:0]] = '0;
                busy_nxt[i_proc[IDX_W-1:0]] = '0;
                blk_nxt[i_proc[IDX_W-1:0]] = 1'b0;
              end
            end
          end
        end
      end
      ST_TDIV, ST_UDIV: begin
        rem_nxt = rem_ge ? rem_sub : rem_sh;
        dvd_nxt = {dvd_r[20:0], rem_ge};
        cnt_nxt = cnt_r - 5'd1;
        if (state_r == ST_TDIV && cnt_r == 5'd1) begin
          ticks_nxt = ({dvd_r[20:0], rem_ge} == 22'd0) ? 22'd1 : {dvd_r[20:0], rem_ge};
        end
        if (state_r == ST_UDIV && cnt_r == 5'd1) begin
          ppm_nxt = {dvd_r[18:0], rem_ge};
        end
      end
      ST_SLOT: begin
        ppm_nxt = PPM_FULL;
        if (!act_r[idx_r]) begin
          if (idx_r == LAST_IDX) begin
            if (rep_r) win_nxt = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ST_MUL: prod_nxt = {20'd0, busy_r[idx_r]} * {21'd0, PPM_FULL};
      ST_DLD: begin
        rem_nxt = {2'd0, prod_r[40:20]};
        dvd_nxt = {prod_r[19:0], 2'd0};
        dvs_nxt = ticks_r;
        cnt_nxt = UDIV_STEPS;
      end
      ST_USE: begin
        if (ofree) begin
          ov_nxt = 1'b1;
          okind_nxt = KIND_USE;
          oslot_nxt = 4'(idx_r);
          oppm_nxt = ppm_r;
          olast_nxt = 1'b0;
          oup_nxt = '0;
          busy_nxt[idx_r] = '0;
        end
      end
      ST_SLEEP: begin
        if (sleep_r[idx_r] != 24'd0) begin
          sleep_nxt[idx_r] = sleep_r[idx_r] - 24'd1;
          if (sleep_r[idx_r] == 24'd1) blk_nxt[idx_r] = 1'b0;
        end
        if (sleep_r[idx_r] != 24'd1) begin
          if (idx_r == LAST_IDX) begin
            if (rep_r) win_nxt = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ST_WAKE: begin
        if (ofree) begin
          ov_nxt = 1'b1;
          okind_nxt = KIND_WAKE;
          oslot_nxt = 4'(idx_r);
          oppm_nxt = '0;
          olast_nxt = 1'b0;
          oup_nxt = '0;
          if (idx_r == LAST_IDX) begin
            if (rep_r) win_nxt = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ST_EXEC: begin
        if (exe_ok && !blk_r[exe_r[IDX_W-1:0]] &&
            busy_r[exe_r[IDX_W-1:0]] < BUSY_MAX) begin
          busy_nxt[exe_r[IDX_W-1:0]] = busy_r[exe_r[IDX_W-1:0]] + 21'd1;
        end
      end
      ST_DONE: begin
        if (ofree) begin
          ov_nxt = 1'b1;
          okind_nxt = KIND_DONE;
          oslot_nxt = '0;
          oppm_nxt = '0;
          olast_nxt = 1'b1;
          oup_nxt = {sec_r, min_r, hr_r, day_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iv_r <= IV_RESET;
      act_r <= '0;
      blk_r <= '0;
      for (int i = 0; i < NUM_PROC; i++) begin
        sleep_r[i] <= '0;
        busy_r[i] <= '0;
      end
      win_r <= '0;
      lrtc_r <= '0;
      seen_r <= 1'b0;
      sec_r <= '0;
      min_r <= '0;
      hr_r <= '0;
      day_r <= '0;
      rep_r <= 1'b0;
      idx_r <= '0;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_IV) iv_r <= cfg_pwdata[19:0];
      act_r <= act_nxt;
      blk_r <= blk_nxt;
      sleep_r <= sleep_nxt;
      busy_r <= busy_nxt;
      win_r <= win_nxt;
      lrtc_r <= lrtc_nxt;
      seen_r <= seen_nxt;
      sec_r <= sec_nxt;
      min_r <= min_nxt;
      hr_r <= hr_nxt;
      day_r <= day_nxt;
      rep_r <= rep_nxt;
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    exe_r <= exe_nxt;
    exev_r <= exev_nxt;
    ticks_r <= ticks_nxt;
    prod_r <= prod_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    ppm_r <= ppm_nxt;
    okind_r <= okind_nxt;
    oslot_r <= oslot_nxt;
    oppm_r <= oppm_nxt;
    olast_r <= olast_nxt;
    oup_r <= oup_nxt;
  end

endmodule
